@@ design/stmm_pkg.sv @@
// stmm_pkg: shared types and constants for the segment tree min/max block
// field widths, function and register codes, sequencer states, bus structs
// no dependencies
`default_nettype none

package stmm_pkg;

    localparam int DATA_W    = 32;
    localparam int IDX_W     = 10;
    localparam int CNT_W     = 11;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 32;

    localparam logic [CNT_W-1:0] COUNT_RESET = 11'd1024;

    // item function codes
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // combine mode codes
    localparam logic MODE_MAX = 1'b0;
    localparam logic MODE_MIN = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EMPTY = 2'd2;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_WDESC,
        S_WUP_A,
        S_WUP_B,
        S_WUP_C,
        S_QVISIT,
        S_QDRAIN,
        S_QFIN
    } state_t;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } ram_ctl_t;

    typedef struct packed {
        logic clearing;
        logic busy;
    } stat_t;

endpackage

`default_nettype wire

@@ design/segment_tree_range_minmax.sv @@
// segment_tree_range_minmax: heap-ordered segment tree, point writes, range max/min
// a write descends to its leaf, then makes three node ram accesses per level on the way up;
// a query visits one node per cycle (at most about four per level), then drains and
// finishes; one item at a time, ready only when idle
// reset: registers go to their reset values, then a clearing pass zeroes all
// 2*MAX_ENTRIES node ram entries; no item is taken during it, config writes are
`default_nettype none

module segment_tree_range_minmax #(
    parameter int MAX_ENTRIES = 1024
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // configuration write port
    input  wire logic                                cfg_we,
    input  wire logic [stmm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [stmm_pkg::CFG_W-1:0]          cfg_data,
    // input items
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic                                func,
    input  wire logic [stmm_pkg::IDX_W-1:0]          first_index,
    input  wire logic [stmm_pkg::IDX_W-1:0]          last_index,
    input  wire logic signed [stmm_pkg::DATA_W-1:0]  new_value,
    // result items
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic signed [stmm_pkg::DATA_W-1:0]       query_result
);

    // node store: root at 1, children of n at 2n and 2n+1, entry 0 unused
    localparam int TN   = 2 * MAX_ENTRIES;
    localparam int AW   = $clog2(TN);
    localparam int EW   = $clog2(MAX_ENTRIES);
    localparam int CMPW = (EW > stmm_pkg::IDX_W) ? EW : stmm_pkg::IDX_W;
    localparam int NCW  = CMPW + 1;

    // configuration registers
    logic                               mode_reg;
    logic [stmm_pkg::CNT_W-1:0]         count_reg;
    logic signed [stmm_pkg::DATA_W-1:0] empty_reg;

    // output stage, lets the sequencer finish while a result waits
    logic                               out_valid_reg, out_valid_next;
    logic signed [stmm_pkg::DATA_W-1:0] out_data_reg;

    logic [NCW-1:0]  count_ext;
    logic [CMPW-1:0] n_last;
    logic            res_valid;
    logic            res_ready;
    logic signed [stmm_pkg::DATA_W-1:0] res_data;

    stmm_pkg::stat_t    stat;
    stmm_pkg::ram_ctl_t ram_ctl;
    logic [AW-1:0]      ram_waddr;
    logic [AW-1:0]      ram_raddr;
    logic signed [stmm_pkg::DATA_W-1:0] ram_wdata;
    logic signed [stmm_pkg::DATA_W-1:0] ram_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= stmm_pkg::MODE_MAX;
            count_reg <= stmm_pkg::COUNT_RESET;
            empty_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                stmm_pkg::CFG_MODE:  mode_reg  <= cfg_data[0];
                stmm_pkg::CFG_COUNT: count_reg <= cfg_data[stmm_pkg::CNT_W-1:0];
                stmm_pkg::CFG_EMPTY: empty_reg <= cfg_data;
                default:             mode_reg  <= mode_reg;
            endcase
        end
    end

    // entry count clamped to 1..MAX_ENTRIES, handed down as the last element index
    assign count_ext = NCW'(count_reg);

    always_comb
    begin
        if (count_ext == '0)
        begin
            n_last = '0;
        end
        else if (count_ext > NCW'(MAX_ENTRIES))
        begin
            n_last = CMPW'(MAX_ENTRIES - 1);
        end
        else
        begin
            n_last = CMPW'(count_ext - NCW'(1));
        end
    end

    stmm_ctrl #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .AW          (AW),
        .CMPW        (CMPW)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .func        (func),
        .first_index (first_index),
        .last_index  (last_index),
        .new_value   (new_value),
        .mode        (mode_reg),
        .empty_value (empty_reg),
        .n_last      (n_last),
        .res_valid   (res_valid),
        .res_data    (res_data),
        .res_ready   (res_ready),
        .stat        (stat),
        .ram_ctl     (ram_ctl),
        .ram_waddr   (ram_waddr),
        .ram_wdata   (ram_wdata),
        .ram_raddr   (ram_raddr),
        .ram_rdata   (ram_rdata)
    );

    stmm_node_ram #(
        .DEPTH (TN),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .ctl   (ram_ctl),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // result slot is free when empty or being drained this cycle
    assign res_ready = !out_valid_reg || out_ready;

    always_comb
    begin
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_data_reg <= res_data;
        end
    end

    assign out_valid    = out_valid_reg;
    assign query_result = out_data_reg;

    // no item is taken while the node ram is being cleared
    a_no_take_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        stat.clearing |-> !in_ready)
        else $error("item port ready during clearing pass");

    // a query always occupies the sequencer past its accept cycle
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && func == stmm_pkg::FUNC_QUERY) |=> (!in_ready && stat.busy))
        else $error("sequencer idle right after a query was taken");

    // a finished query lands in the output stage
    a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_ready) |=> out_valid)
        else $error("finished query did not reach the output stage");

    // clamped element range stays inside the store
    a_count_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        n_last <= CMPW'(MAX_ENTRIES - 1))
        else $error("entry count clamp out of range");

endmodule

`default_nettype wire

@@ design/stmm_combine.sv @@
// stmm_combine: shared signed max/min compare unit
// depends on stmm_pkg
`default_nettype none

module stmm_combine (
    input  wire logic                                mode,
    input  wire logic signed [stmm_pkg::DATA_W-1:0]  a,
    input  wire logic signed [stmm_pkg::DATA_W-1:0]  b,
    output logic signed [stmm_pkg::DATA_W-1:0]       y
);

    logic a_less;

    assign a_less = (a < b);

    always_comb
    begin
        if (mode == stmm_pkg::MODE_MIN)
        begin
            y = a_less ? a : b;
        end
        else
        begin
            y = (a > b) ? a : b;
        end
    end

endmodule

`default_nettype wire

@@ design/stmm_node_ram.sv @@
// stmm_node_ram: tree node store, one write and one registered read per cycle
// depends on stmm_pkg
`default_nettype none

module stmm_node_ram #(
    parameter int DEPTH = 2048,
    parameter int AW    = 11
) (
    input  wire logic                                clk,
    input  wire stmm_pkg::ram_ctl_t                  ctl,
    input  wire logic [AW-1:0]                       waddr,
    input  wire logic signed [stmm_pkg::DATA_W-1:0]  wdata,
    input  wire logic [AW-1:0]                       raddr,
    output logic signed [stmm_pkg::DATA_W-1:0]       rdata
);

    logic signed [stmm_pkg::DATA_W-1:0] mem [DEPTH];
    logic signed [stmm_pkg::DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[waddr] <= wdata;
        end
        if (ctl.rd_en)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ design/stmm_ctrl.sv @@
// stmm_ctrl: sequencer for tree writes and range queries with a node stack
// depends on stmm_pkg, stmm_combine
`default_nettype none

module stmm_ctrl #(
    parameter int MAX_ENTRIES = 1024,
    parameter int AW          = 11,
    parameter int CMPW        = 10
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic                                func,
    input  wire logic [stmm_pkg::IDX_W-1:0]          first_index,
    input  wire logic [stmm_pkg::IDX_W-1:0]          last_index,
    input  wire logic signed [stmm_pkg::DATA_W-1:0]  new_value,
    input  wire logic                                mode,
    input  wire logic signed [stmm_pkg::DATA_W-1:0]  empty_value,
    input  wire logic [CMPW-1:0]                     n_last,
    output logic                                     res_valid,
    output logic signed [stmm_pkg::DATA_W-1:0]       res_data,
    input  wire logic                                res_ready,
    output stmm_pkg::stat_t                          stat,
    output stmm_pkg::ram_ctl_t                       ram_ctl,
    output logic [AW-1:0]                            ram_waddr,
    output logic signed [stmm_pkg::DATA_W-1:0]       ram_wdata,
    output logic [AW-1:0]                            ram_raddr,
    input  wire logic signed [stmm_pkg::DATA_W-1:0]  ram_rdata
);

    localparam int TN     = 2 * MAX_ENTRIES;
    localparam int NW     = AW + 1;
    localparam int SD     = $clog2(MAX_ENTRIES);
    localparam int SAW    = (SD > 1) ? $clog2(SD) : 1;
    localparam int SDEPTH = 2 ** SAW;
    localparam int SPW    = SAW + 1;

    stmm_pkg::state_t state_reg, state_next;

    logic [AW-1:0]   clr_reg, clr_next;
    logic [CMPW-1:0] lo_reg, lo_next;
    logic [CMPW-1:0] hi_reg, hi_next;
    logic [NW-1:0]   node_reg, node_next;
    logic [CMPW-1:0] a_reg, a_next;
    logic [CMPW-1:0] b_reg, b_next;
    logic signed [stmm_pkg::DATA_W-1:0] val_reg, val_next;
    logic signed [stmm_pkg::DATA_W-1:0] tmp_reg, tmp_next;
    logic signed [stmm_pkg::DATA_W-1:0] acc_reg, acc_next;
    logic            accv_reg, accv_next;
    logic            hit_reg, hit_next;
    logic            pend_reg, pend_next;
    logic [SPW-1:0]  sp_reg, sp_next;

    // stack of right children still to visit
    logic [CMPW-1:0] stk_lo_reg   [SDEPTH];
    logic [CMPW-1:0] stk_hi_reg   [SDEPTH];
    logic [NW-1:0]   stk_node_reg [SDEPTH];

    logic            push;
    logic [CMPW:0]   sum;
    logic [CMPW-1:0] mid;
    logic [CMPW-1:0] mid_up;
    logic [NW-1:0]   lchild;
    logic [NW-1:0]   rchild;
    logic [NW-1:0]   parent;
    logic            node_in;
    logic            disjoint;
    logic            covered;
    logic [SPW-1:0]  sp_dec;
    logic [SAW-1:0]  top;
    logic signed [stmm_pkg::DATA_W-1:0] comb_a;
    logic signed [stmm_pkg::DATA_W-1:0] comb_b;
    logic signed [stmm_pkg::DATA_W-1:0] comb_y;

    assign sum      = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid      = sum[CMPW:1];
    assign mid_up   = mid + CMPW'(1);
    assign lchild   = {node_reg[NW-2:0], 1'b0};
    assign rchild   = {node_reg[NW-2:0], 1'b1};
    assign parent   = {1'b0, node_reg[NW-1:1]};
    assign node_in  = (node_reg < NW'(TN));
    assign disjoint = (hi_reg < a_reg) || (b_reg < lo_reg);
    assign covered  = (a_reg <= lo_reg) && (hi_reg <= b_reg);
    assign sp_dec   = sp_reg - SPW'(1);
    assign top      = sp_dec[SAW-1:0];

    // one compare unit shared by recombine, accumulate and final merge
    assign comb_a = (state_reg == stmm_pkg::S_WUP_C) ? tmp_reg : acc_reg;
    assign comb_b = (state_reg == stmm_pkg::S_QFIN) ? empty_value : ram_rdata;

    stmm_combine u_combine (
        .mode (mode),
        .a    (comb_a),
        .b    (comb_b),
        .y    (comb_y)
    );

    always_comb
    begin
        if (!accv_reg)
        begin
            res_data = empty_value;
        end
        else if (hit_reg)
        begin
            res_data = comb_y;
        end
        else
        begin
            res_data = acc_reg;
        end
    end

    assign stat.clearing = (state_reg == stmm_pkg::S_CLEAR);
    assign stat.busy     = (state_reg != stmm_pkg::S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        node_next  = node_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        val_next   = val_reg;
        tmp_next   = tmp_reg;
        acc_next   = acc_reg;
        accv_next  = accv_reg;
        hit_next   = hit_reg;
        pend_next  = 1'b0;
        sp_next    = sp_reg;
        push       = 1'b0;
        ram_ctl    = '0;
        ram_waddr  = '0;
        ram_wdata  = '0;
        ram_raddr  = '0;
        in_ready   = 1'b0;
        res_valid  = 1'b0;

        // fold in the node read issued last cycle
        if (pend_reg)
        begin
            acc_next  = accv_reg ? comb_y : ram_rdata;
            accv_next = 1'b1;
        end

        case (state_reg)
            stmm_pkg::S_CLEAR:
            begin
                ram_ctl.wr_en = 1'b1;
                ram_waddr     = clr_reg;
                ram_wdata     = '0;
                if (clr_reg == AW'(TN - 1))
                begin
                    state_next = stmm_pkg::S_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + AW'(1);
                end
            end

            stmm_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    a_next    = CMPW'(first_index);
                    b_next    = CMPW'(last_index);
                    val_next  = new_value;
                    lo_next   = '0;
                    hi_next   = n_last;
                    node_next = NW'(1);
                    sp_next   = '0;
                    accv_next = 1'b0;
                    hit_next  = 1'b0;
                    if (func == stmm_pkg::FUNC_QUERY)
                    begin
                        state_next = stmm_pkg::S_QVISIT;
                    end
                    else if (CMPW'(first_index) <= n_last)
                    begin
                        state_next = stmm_pkg::S_WDESC;
                    end
                end
            end

            stmm_pkg::S_WDESC:
            begin
                if (!node_in)
                begin
                    state_next = stmm_pkg::S_WUP_A;
                end
                else if (lo_reg >= hi_reg)
                begin
                    ram_ctl.wr_en = 1'b1;
                    ram_waddr     = node_reg[AW-1:0];
                    ram_wdata     = val_reg;
                    state_next    = stmm_pkg::S_WUP_A;
                end
                else if (a_reg <= mid)
                begin
                    hi_next   = mid;
                    node_next = lchild;
                end
                else
                begin
                    lo_next   = mid_up;
                    node_next = rchild;
                end
            end

            stmm_pkg::S_WUP_A:
            begin
                if (parent == '0)
                begin
                    state_next = stmm_pkg::S_IDLE;
                end
                else
                begin
                    node_next = parent;
                    // only parents whose both children sit in the store recombine
                    if (parent < NW'(MAX_ENTRIES))
                    begin
                        ram_ctl.rd_en = 1'b1;
                        ram_raddr     = {parent[AW-2:0], 1'b0};
                        state_next    = stmm_pkg::S_WUP_B;
                    end
                end
            end

            stmm_pkg::S_WUP_B:
            begin
                ram_ctl.rd_en = 1'b1;
                ram_raddr     = {node_reg[AW-2:0], 1'b1};
                tmp_next      = ram_rdata;
                state_next    = stmm_pkg::S_WUP_C;
            end

            stmm_pkg::S_WUP_C:
            begin
                ram_ctl.wr_en = 1'b1;
                ram_waddr     = node_reg[AW-1:0];
                ram_wdata     = comb_y;
                state_next    = stmm_pkg::S_WUP_A;
            end

            stmm_pkg::S_QVISIT:
            begin
                if (disjoint || !node_in || covered)
                begin
                    if (disjoint || !node_in)
                    begin
                        hit_next = 1'b1;
                    end
                    else
                    begin
                        ram_ctl.rd_en = 1'b1;
                        ram_raddr     = node_reg[AW-1:0];
                        pend_next     = 1'b1;
                    end
                    if (sp_reg == '0)
                    begin
                        state_next = stmm_pkg::S_QDRAIN;
                    end
                    else
                    begin
                        lo_next   = stk_lo_reg[top];
                        hi_next   = stk_hi_reg[top];
                        node_next = stk_node_reg[top];
                        sp_next   = sp_dec;
                    end
                end
                else
                begin
                    push      = 1'b1;
                    sp_next   = sp_reg + SPW'(1);
                    hi_next   = mid;
                    node_next = lchild;
                end
            end

            stmm_pkg::S_QDRAIN:
            begin
                state_next = stmm_pkg::S_QFIN;
            end

            stmm_pkg::S_QFIN:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = stmm_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = stmm_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= stmm_pkg::S_CLEAR;
            clr_reg   <= '0;
            sp_reg    <= '0;
            pend_reg  <= 1'b0;
            accv_reg  <= 1'b0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            sp_reg    <= sp_next;
            pend_reg  <= pend_next;
            accv_reg  <= accv_next;
            hit_reg   <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        node_reg <= node_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        val_reg  <= val_next;
        tmp_reg  <= tmp_next;
        acc_reg  <= acc_next;
        if (push)
        begin
            stk_lo_reg[sp_reg[SAW-1:0]]   <= mid_up;
            stk_hi_reg[sp_reg[SAW-1:0]]   <= hi_reg;
            stk_node_reg[sp_reg[SAW-1:0]] <= rchild;
        end
    end

endmodule

`default_nettype wire
